/* design/qpn_pkg.sv */
// shared types and constants for the quaternion product and normalize block
`default_nettype none

package qpn_pkg;

   // default fraction bits of the result words
   localparam int FRAC_BITS_DEF = 30;
   // default depth of the queue between front and back
   localparam int QUEUE_DEPTH_DEF = 4;

   // width of a block-scaled magnitude; the largest of a nonzero word lies in [2^30, 2^31)
   localparam int C_W = 31;

   // lane numbers: vector x, y, z and scalar w
   localparam int LANE_X = 0;
   localparam int LANE_Y = 1;
   localparam int LANE_Z = 2;
   localparam int LANE_W = 3;

   // input word: two quaternions
   typedef struct packed {
      logic signed [31:0] a_x;
      logic signed [31:0] a_y;
      logic signed [31:0] a_z;
      logic signed [31:0] a_w;
      logic signed [31:0] b_x;
      logic signed [31:0] b_y;
      logic signed [31:0] b_z;
      logic signed [31:0] b_w;
   } req_type;

   // result word: unit quaternion with non-negative scalar part
   typedef struct packed {
      logic signed [31:0] r_x;
      logic signed [31:0] r_y;
      logic signed [31:0] r_z;
      logic [30:0]        r_w;
      logic               zero_norm;
   } rsp_type;

   // classified product between front and back
   typedef struct packed {
      logic [3:0][C_W-1:0] c;
      logic [3:0]          neg;
      logic                zero;
   } mid_type;

endpackage

`default_nettype wire

/* design/qpn_front.sv */
// front end: prescale, hamilton product, magnitude, block scaling
`default_nettype none

module qpn_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_push,
   input  wire qpn_pkg::req_type req_data,
   output logic                  req_full,
   output logic                  mid_valid,
   output qpn_pkg::mid_type      mid_data,
   input  wire logic             mid_full
);

   localparam int NSTG = 7;

   // magnitude of at least 2^30
   function automatic logic is_big(input logic signed [31:0] v);
      return (v > 32'sd1073741823) || (v < -32'sd1073741823);
   endfunction

   function automatic logic signed [61:0] mulw(input logic signed [30:0] x,
                                               input logic signed [30:0] y);
      return 62'(x) * 62'(y);
   endfunction

   logic                adv;
   logic [NSTG-1:0]     v_ff;

   logic signed [31:0]  ra [4];
   logic signed [31:0]  rb [4];
   logic                big_a;
   logic                big_b;
   logic signed [30:0]  a_in [4];
   logic signed [30:0]  b_in [4];
   logic signed [30:0]  a_ff [4];
   logic signed [30:0]  b_ff [4];
   logic signed [61:0]  t_in [4][4];
   logic signed [61:0]  t_ff [4][4];
   logic signed [63:0]  p_in [4];
   logic signed [63:0]  p_ff [4];
   logic [62:0]         mag_in [4];
   logic [62:0]         mag4_ff [4];
   logic [3:0]          neg_in;
   logic [3:0]          neg4_ff;
   logic [63:0]         orv;
   logic [7:0]          gnz_in;
   logic [2:0]          gpos_in [8];
   logic [7:0]          gnz_ff;
   logic [2:0]          gpos_ff [8];
   logic [62:0]         mag5_ff [4];
   logic [3:0]          neg5_ff;
   logic [5:0]          pos_in;
   logic                zero_in;
   logic [5:0]          pos_ff;
   logic                zero6_ff;
   logic [62:0]         mag6_ff [4];
   logic [3:0]          neg6_ff;
   qpn_pkg::mid_type    mid_in;
   qpn_pkg::mid_type    mid_ff;

   // whole front moves unless the last word is stuck at a full queue
   assign adv       = !v_ff[NSTG-1] || !mid_full;
   assign req_full  = !adv;
   assign mid_valid = v_ff[NSTG-1];
   assign mid_data  = mid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[NSTG-2:0], req_push};
      end
   end

   // prescale: halve a quaternion if any part reaches 2^30
   always_comb begin
      ra[0] = req_data.a_x;
      ra[1] = req_data.a_y;
      ra[2] = req_data.a_z;
      ra[3] = req_data.a_w;
      rb[0] = req_data.b_x;
      rb[1] = req_data.b_y;
      rb[2] = req_data.b_z;
      rb[3] = req_data.b_w;
      big_a = is_big(ra[0]) || is_big(ra[1]) || is_big(ra[2]) || is_big(ra[3]);
      big_b = is_big(rb[0]) || is_big(rb[1]) || is_big(rb[2]) || is_big(rb[3]);
      for (int i = 0; i < 4; i++) begin
         a_in[i] = big_a ? 31'(ra[i] >>> 1) : 31'(ra[i]);
         b_in[i] = big_b ? 31'(rb[i] >>> 1) : 31'(rb[i]);
      end
   end

   // sixteen partial products
   always_comb begin
      t_in[0][0] = mulw(a_ff[3], b_ff[0]);
      t_in[0][1] = mulw(b_ff[3], a_ff[0]);
      t_in[0][2] = mulw(a_ff[1], b_ff[2]);
      t_in[0][3] = mulw(a_ff[2], b_ff[1]);
      t_in[1][0] = mulw(a_ff[3], b_ff[1]);
      t_in[1][1] = mulw(b_ff[3], a_ff[1]);
      t_in[1][2] = mulw(a_ff[2], b_ff[0]);
      t_in[1][3] = mulw(a_ff[0], b_ff[2]);
      t_in[2][0] = mulw(a_ff[3], b_ff[2]);
      t_in[2][1] = mulw(b_ff[3], a_ff[2]);
      t_in[2][2] = mulw(a_ff[0], b_ff[1]);
      t_in[2][3] = mulw(a_ff[1], b_ff[0]);
      t_in[3][0] = mulw(a_ff[3], b_ff[3]);
      t_in[3][1] = mulw(a_ff[0], b_ff[0]);
      t_in[3][2] = mulw(a_ff[1], b_ff[1]);
      t_in[3][3] = mulw(a_ff[2], b_ff[2]);
   end

   // product parts
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         p_in[i] = 64'(t_ff[i][0]) + 64'(t_ff[i][1]) + 64'(t_ff[i][2]) - 64'(t_ff[i][3]);
      end
      p_in[3] = 64'(t_ff[3][0]) - 64'(t_ff[3][1]) - 64'(t_ff[3][2]) - 64'(t_ff[3][3]);
   end

   // sign and magnitude
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         neg_in[i] = p_ff[i][63];
         mag_in[i] = p_ff[i][63] ? 63'(-p_ff[i]) : 63'(p_ff[i]);
      end
   end

   // leading one search, first per byte of the or of all magnitudes
   always_comb begin
      orv = {1'b0, mag4_ff[0] | mag4_ff[1] | mag4_ff[2] | mag4_ff[3]};
      for (int g = 0; g < 8; g++) begin
         gnz_in[g]  = |orv[8*g +: 8];
         gpos_in[g] = '0;
         for (int b = 0; b < 8; b++) begin
            if (orv[8*g + b]) begin
               gpos_in[g] = 3'(b);
            end
         end
      end
   end

   // then across bytes
   always_comb begin
      pos_in  = '0;
      zero_in = ~|gnz_ff;
      for (int g = 0; g < 8; g++) begin
         if (gnz_ff[g]) begin
            pos_in = {3'(g), gpos_ff[g]};
         end
      end
   end

   // common shift puts the largest magnitude in [2^30, 2^31)
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         if (pos_ff >= 6'd30) begin
            mid_in.c[i] = 31'(mag6_ff[i] >> (pos_ff - 6'd30));
         end else begin
            mid_in.c[i] = 31'(mag6_ff[i] << (6'd30 - pos_ff));
         end
      end
      mid_in.neg  = neg6_ff;
      mid_in.zero = zero6_ff;
   end

   // pipeline payload
   always_ff @(posedge clock) begin
      if (adv) begin
         a_ff     <= a_in;
         b_ff     <= b_in;
         t_ff     <= t_in;
         p_ff     <= p_in;
         mag4_ff  <= mag_in;
         neg4_ff  <= neg_in;
         gnz_ff   <= gnz_in;
         gpos_ff  <= gpos_in;
         mag5_ff  <= mag4_ff;
         neg5_ff  <= neg4_ff;
         pos_ff   <= pos_in;
         zero6_ff <= zero_in;
         mag6_ff  <= mag5_ff;
         neg6_ff  <= neg5_ff;
         mid_ff   <= mid_in;
      end
   end

   // a nonzero product leaves the front normalized
   a_norm: assert property (@(posedge clock) disable iff (reset)
      v_ff[NSTG-1] && !mid_ff.zero |->
         (mid_ff.c[0][30] || mid_ff.c[1][30] || mid_ff.c[2][30] || mid_ff.c[3][30]))
      else $error("front word not normalized");

endmodule

`default_nettype wire

/* design/qpn_queue.sv */
// short queue of classified words between front and back
`default_nettype none

module qpn_queue #(
   parameter int DEPTH = qpn_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire qpn_pkg::mid_type wdata,
   output logic                  full,
   input  wire logic             pop,
   output qpn_pkg::mid_type      rdata,
   output logic                  empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [PTR_W-1:0] wr_ff;
   logic [PTR_W-1:0] rd_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             do_push;
   logic             do_pop;
   qpn_pkg::mid_type mem_ff [DEPTH];

   assign full    = cnt_ff == CNT_W'(DEPTH);
   assign empty   = cnt_ff == '0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ff];

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ff <= (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ff <= (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= wdata;
      end
   end

   a_cnt_max: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(DEPTH))
      else $error("queue count beyond depth");

   a_cnt_up: assert property (@(posedge clock) disable iff (reset)
      do_push && !do_pop |=> cnt_ff == CNT_W'($past(cnt_ff) + 1'b1))
      else $error("queue count missed a push");

endmodule

`default_nettype wire

/* design/qpn_back.sv */
// back end: sum of squares, pipelined root, four-lane divide, sign fold
`default_nettype none

module qpn_back #(
   parameter int FRAC_BITS = qpn_pkg::FRAC_BITS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             mid_empty,
   input  wire qpn_pkg::mid_type mid_data,
   output logic                  mid_pop,
   input  wire logic             rsp_pop,
   output qpn_pkg::rsp_type      rsp_data,
   output logic                  rsp_empty
);

   localparam int C_W    = qpn_pkg::C_W;
   localparam int RT_W   = 32;
   localparam int RT_STG = 32;
   localparam int REM_W  = 35;
   localparam int NUM_W  = C_W + FRAC_BITS + 1;
   localparam int DV_N   = FRAC_BITS + 2;
   localparam logic [FRAC_BITS:0] ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};

   logic                     adv;

   logic                     b1_v_ff;
   qpn_pkg::mid_type         b1_side_ff;
   logic [61:0]              b1_sq_ff [4];

   logic                     sq_v_ff    [RT_STG+1];
   logic [63:0]              sq_s_ff    [RT_STG+1];
   logic [REM_W-1:0]         sq_rem_ff  [RT_STG+1];
   logic [RT_W-1:0]          sq_root_ff [RT_STG+1];
   qpn_pkg::mid_type         sq_side_ff [RT_STG+1];

   logic                     dv_v_ff    [DV_N];
   logic [3:0][31:0]         dv_rem_ff  [DV_N];
   logic [3:0][FRAC_BITS:0]  dv_low_ff  [DV_N];
   logic [3:0][FRAC_BITS:0]  dv_q_ff    [DV_N];
   logic [31:0]              dv_n_ff    [DV_N];
   logic [3:0]               dv_neg_ff  [DV_N];
   logic                     dv_zero_ff [DV_N];

   logic [3:0][31:0]         pre_rem;
   logic [3:0][FRAC_BITS:0]  pre_low;
   logic [NUM_W-1:0]         num [4];

   logic [FRAC_BITS:0]       qs [4];
   logic [31:0]              rv [4];
   logic [3:0]               sg;
   qpn_pkg::rsp_type         out_in;
   qpn_pkg::rsp_type         out_ff;
   logic                     out_v_ff;

   // back moves whenever the output register is free or being taken
   assign adv       = !out_v_ff || rsp_pop;
   assign mid_pop   = adv && !mid_empty;
   assign rsp_data  = out_ff;
   assign rsp_empty = !out_v_ff;

   // squares of the scaled parts
   always_ff @(posedge clock) begin
      if (reset) begin
         b1_v_ff <= 1'b0;
      end else if (adv) begin
         b1_v_ff <= !mid_empty;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b1_side_ff <= mid_data;
         for (int i = 0; i < 4; i++) begin
            b1_sq_ff[i] <= 62'(mid_data.c[i]) * 62'(mid_data.c[i]);
         end
      end
   end

   // sum of squares feeds the root
   always_ff @(posedge clock) begin
      if (reset) begin
         sq_v_ff[0] <= 1'b0;
      end else if (adv) begin
         sq_v_ff[0] <= b1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_s_ff[0]    <= 64'(b1_sq_ff[0]) + 64'(b1_sq_ff[1])
                        + 64'(b1_sq_ff[2]) + 64'(b1_sq_ff[3]);
         sq_rem_ff[0]  <= '0;
         sq_root_ff[0] <= '0;
         sq_side_ff[0] <= b1_side_ff;
      end
   end

   // integer square root, one result bit per stage
   for (genvar k = 0; k < RT_STG; k++) begin : g_root
      logic [REM_W-1:0] shifted;
      logic [REM_W-1:0] trial;
      logic             ge;

      assign shifted = {sq_rem_ff[k][REM_W-3:0], sq_s_ff[k][2*(RT_STG-1-k) +: 2]};
      assign trial   = REM_W'({sq_root_ff[k], 2'b01});
      assign ge      = shifted >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_v_ff[k+1] <= 1'b0;
         end else if (adv) begin
            sq_v_ff[k+1] <= sq_v_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            sq_s_ff[k+1]    <= sq_s_ff[k];
            sq_rem_ff[k+1]  <= ge ? shifted - trial : shifted;
            sq_root_ff[k+1] <= {sq_root_ff[k][RT_W-2:0], ge};
            sq_side_ff[k+1] <= sq_side_ff[k];
         end
      end
   end

   // dividend |c| * 2^frac + n/2, top bits seed the remainder
   always_comb begin
      for (int l = 0; l < 4; l++) begin
         num[l] = NUM_W'({sq_side_ff[RT_STG].c[l], {FRAC_BITS{1'b0}}})
                + NUM_W'(sq_root_ff[RT_STG][RT_W-1:1]);
         pre_rem[l] = 32'(num[l][NUM_W-1:FRAC_BITS+1]);
         pre_low[l] = num[l][FRAC_BITS:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_v_ff[0] <= 1'b0;
      end else if (adv) begin
         dv_v_ff[0] <= sq_v_ff[RT_STG];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dv_rem_ff[0]  <= pre_rem;
         dv_low_ff[0]  <= pre_low;
         dv_q_ff[0]    <= '0;
         dv_n_ff[0]    <= sq_root_ff[RT_STG];
         dv_neg_ff[0]  <= sq_side_ff[RT_STG].neg;
         dv_zero_ff[0] <= sq_side_ff[RT_STG].zero;
      end
   end

   // restoring divide, one quotient bit per stage in all four lanes
   for (genvar j = 0; j < FRAC_BITS + 1; j++) begin : g_div
      logic [3:0][32:0] sh;
      logic [3:0]       ge;
      logic [3:0][31:0] rn;

      for (genvar l = 0; l < 4; l++) begin : g_lane
         assign sh[l] = {dv_rem_ff[j][l], dv_low_ff[j][l][FRAC_BITS]};
         assign ge[l] = sh[l] >= {1'b0, dv_n_ff[j]};
         assign rn[l] = ge[l] ? 32'(sh[l] - {1'b0, dv_n_ff[j]}) : sh[l][31:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_v_ff[j+1] <= 1'b0;
         end else if (adv) begin
            dv_v_ff[j+1] <= dv_v_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dv_rem_ff[j+1] <= rn;
            for (int l = 0; l < 4; l++) begin
               dv_low_ff[j+1][l] <= {dv_low_ff[j][l][FRAC_BITS-1:0], 1'b0};
               dv_q_ff[j+1][l]   <= {dv_q_ff[j][l][FRAC_BITS-1:0], ge[l]};
            end
            dv_n_ff[j+1]    <= dv_n_ff[j];
            dv_neg_ff[j+1]  <= dv_neg_ff[j];
            dv_zero_ff[j+1] <= dv_zero_ff[j];
         end
      end
   end

   // saturate, sign, fold on negative scalar, identity for a zero product
   always_comb begin
      for (int l = 0; l < 4; l++) begin
         qs[l] = (dv_q_ff[DV_N-1][l] > ONE_Q) ? ONE_Q : dv_q_ff[DV_N-1][l];
         sg[l] = (dv_neg_ff[DV_N-1][l] ^ dv_neg_ff[DV_N-1][qpn_pkg::LANE_W])
               && (qs[l] != '0);
         rv[l] = sg[l] ? -32'(qs[l]) : 32'(qs[l]);
      end
      if (dv_zero_ff[DV_N-1]) begin
         out_in.r_x       = '0;
         out_in.r_y       = '0;
         out_in.r_z       = '0;
         out_in.r_w       = 31'(ONE_Q);
         out_in.zero_norm = 1'b1;
      end else begin
         out_in.r_x       = rv[qpn_pkg::LANE_X];
         out_in.r_y       = rv[qpn_pkg::LANE_Y];
         out_in.r_z       = rv[qpn_pkg::LANE_Z];
         out_in.r_w       = 31'(qs[qpn_pkg::LANE_W]);
         out_in.zero_norm = 1'b0;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (adv) begin
         out_v_ff <= dv_v_ff[DV_N-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_ff <= out_in;
      end
   end

   a_ident: assert property (@(posedge clock) disable iff (reset)
      out_v_ff && out_ff.zero_norm |->
         out_ff.r_x == '0 && out_ff.r_y == '0 && out_ff.r_z == '0
         && out_ff.r_w == 31'(ONE_Q))
      else $error("zero product without identity result");

   a_unit_w: assert property (@(posedge clock) disable iff (reset)
      out_v_ff |-> out_ff.r_w <= 31'(ONE_Q))
      else $error("scalar part above one");

   a_load: assert property (@(posedge clock) disable iff (reset)
      mid_pop |=> b1_v_ff)
      else $error("queue word lost entering back");

endmodule

`default_nettype wire

/* design/quaternion_product_normalize.sv */
// Hamilton product of two Q1.30 quaternions, renormalized to unit length.
// An accepted word passes the front stages, the queue and the back, whose depth is set by
// the 32-stage root and the FRAC_BITS+1 divide stages.
// Throughput: one word per cycle; the front stalls only when the queue is full,
// the back only when the result register is held.
// Reset: synchronous, clears all valid bits and queue pointers; no clearing pass.
`default_nettype none

module quaternion_product_normalize #(
   parameter int FRAC_BITS   = qpn_pkg::FRAC_BITS_DEF,
   parameter int QUEUE_DEPTH = qpn_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_push,
   input  wire qpn_pkg::req_type req_data,
   output logic                  req_full,
   input  wire logic             rsp_pop,
   output qpn_pkg::rsp_type      rsp_data,
   output logic                  rsp_empty
);

   logic             mid_valid;
   qpn_pkg::mid_type mid_wdata;
   logic             mid_full;
   logic             mid_pop;
   qpn_pkg::mid_type mid_rdata;
   logic             mid_empty;

   // product and classification
   qpn_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .mid_valid (mid_valid),
      .mid_data  (mid_wdata),
      .mid_full  (mid_full)
   );

   // decoupling queue
   qpn_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (mid_valid),
      .wdata (mid_wdata),
      .full  (mid_full),
      .pop   (mid_pop),
      .rdata (mid_rdata),
      .empty (mid_empty)
   );

   // root, divide and output
   qpn_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .mid_empty (mid_empty),
      .mid_data  (mid_rdata),
      .mid_pop   (mid_pop),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .rsp_empty (rsp_empty)
   );

endmodule

`default_nettype wire

/* bench/tb_quaternion_product_normalize.sv */
// self-checking bench for quaternion_product_normalize: random and corner quaternion pairs
module tb_quaternion_product_normalize;

   localparam int FRAC = 30;
   localparam int WATCH_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 120;
   localparam int HOLD_CYCLES = 400;

   logic             clock;
   logic             reset;
   logic             req_push;
   qpn_pkg::req_type req_data;
   logic             req_full;
   logic             rsp_pop;
   qpn_pkg::rsp_type rsp_data;
   logic             rsp_empty;

   qpn_pkg::req_type pending_words[$];
   qpn_pkg::rsp_type expected_units[$];
   int      error_count;
   int      sender_idle_pct;
   int      receiver_idle_pct;
   int      hold_left;
   bit      hold_armed;
   int      results_seen;
   int      quiet_cycles;

   quaternion_product_normalize u_top (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .rsp_empty (rsp_empty)
   );

   // clock
   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // halve a quaternion toward minus infinity when any part reaches 2^30
   function automatic void halve_if_big(ref longint q[4]);
      bit big;
      big = 1'b0;
      for (int i = 0; i < 4; i++)
         if (q[i] >= (64'sd1 <<< 30) || q[i] <= -(64'sd1 <<< 30)) big = 1'b1;
      if (big)
         for (int i = 0; i < 4; i++) q[i] = q[i] >>> 1;
   endfunction

   // normalized hamilton product, scalar part folded non-negative
   function automatic qpn_pkg::rsp_type unit_product(qpn_pkg::req_type w);
      longint a[4], b[4], p[4];
      longint unsigned mg[4], m, sum, n, q, one, rem, root, bitv;
      bit neg[4], flip, s;
      int down, up;
      logic [31:0] qq, word[4];
      qpn_pkg::rsp_type r;
      a[0] = w.a_x; a[1] = w.a_y; a[2] = w.a_z; a[3] = w.a_w;
      b[0] = w.b_x; b[1] = w.b_y; b[2] = w.b_z; b[3] = w.b_w;
      halve_if_big(a);
      halve_if_big(b);
      p[0] = a[3] * b[0] + b[3] * a[0] + a[1] * b[2] - a[2] * b[1];
      p[1] = a[3] * b[1] + b[3] * a[1] + a[2] * b[0] - a[0] * b[2];
      p[2] = a[3] * b[2] + b[3] * a[2] + a[0] * b[1] - a[1] * b[0];
      p[3] = a[3] * b[3] - a[0] * b[0] - a[1] * b[1] - a[2] * b[2];
      one = 64'd1 << FRAC;
      m = 0;
      for (int i = 0; i < 4; i++) begin
         neg[i] = p[i] < 0;
         mg[i] = neg[i] ? -p[i] : p[i];
         if (mg[i] > m) m = mg[i];
      end
      r = '0;
      if (m == 0) begin
         r.r_w = one[30:0];
         r.zero_norm = 1'b1;
         return r;
      end
      down = 0;
      up = 0;
      while ((m >> down) >= (64'd1 << 31)) down++;
      while ((m << up) < (64'd1 << 30)) up++;
      sum = 0;
      for (int i = 0; i < 4; i++) begin
         mg[i] = (mg[i] >> down) << up;
         sum += mg[i] * mg[i];
      end
      // integer square root
      rem = sum;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > rem) bitv >>= 2;
      while (bitv != 0) begin
         if (rem >= root + bitv) begin
            rem -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      n = root;
      flip = neg[3];
      for (int i = 0; i < 4; i++) begin
         q = ((mg[i] << FRAC) + (n >> 1)) / n;
         s = neg[i] != flip;
         if (q > one) q = one;
         if (q == 0) s = 1'b0;
         qq = q[31:0];
         word[i] = s ? (~qq + 32'd1) : qq;
      end
      r.r_x = word[qpn_pkg::LANE_X];
      r.r_y = word[qpn_pkg::LANE_Y];
      r.r_z = word[qpn_pkg::LANE_Z];
      r.r_w = word[qpn_pkg::LANE_W][30:0];
      r.zero_norm = 1'b0;
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
      error_count++;
   endtask

   function automatic logic [31:0] pick_corner();
      case ($urandom_range(0, 8))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'h4000_0000;
         3: return 32'hc000_0000;
         4: return 32'h3fff_ffff;
         5: return 32'd1;
         6: return 32'hffff_ffff;
         7: return 32'd0;
         default: return $urandom;
      endcase
   endfunction

   // one random word of a chosen flavor
   function automatic qpn_pkg::req_type random_word();
      logic [31:0] v[8];
      int kind;
      qpn_pkg::req_type w;
      kind = $urandom_range(0, 9);
      for (int i = 0; i < 8; i++) begin
         case (kind)
            0, 1, 2: v[i] = $urandom;
            3, 4:    v[i] = $signed($urandom) >>> $urandom_range(0, 31);
            5:       v[i] = pick_corner();
            6:       v[i] = (i < 4) ? 32'd0 : $urandom;
            7:       v[i] = $urandom_range(0, 1) ? $signed($urandom_range(0, 8)) - 4 : 32'd0;
            8:       v[i] = $signed($urandom) >>> 2;
            default: v[i] = $urandom_range(0, 3) == 0 ? 32'd0 : $urandom;
         endcase
      end
      w = {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7]};
      return w;
   endfunction

   function automatic qpn_pkg::req_type make_word(logic [31:0] ax, logic [31:0] ay,
                                                  logic [31:0] az, logic [31:0] aw,
                                                  logic [31:0] bx, logic [31:0] by,
                                                  logic [31:0] bz, logic [31:0] bw);
      qpn_pkg::req_type w;
      w = {ax, ay, az, aw, bx, by, bz, bw};
      return w;
   endfunction

   // sender: offer the head of the pending list, hold it until taken
   always @(negedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else if (req_push && req_full) begin
         req_push <= 1'b1;
      end else if (pending_words.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
         req_push <= 1'b1;
         req_data <= pending_words[0];
      end else begin
         req_push <= 1'b0;
      end
   end

   // receiver: random stalls plus one long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_pop <= 1'b0;
      end else if (hold_armed && results_seen >= 50) begin
         hold_armed <= 1'b0;
         hold_left <= HOLD_CYCLES;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= $urandom_range(0, 99) >= receiver_idle_pct;
      end
   end

   // accept words, predict, and check results
   always @(posedge clock) begin
      qpn_pkg::rsp_type want;
      bit moved;
      moved = 1'b0;
      if (!reset) begin
         if (req_push && !req_full) begin
            expected_units.push_back(unit_product(pending_words[0]));
            void'(pending_words.pop_front());
            moved = 1'b1;
         end
         if (rsp_pop && !rsp_empty) begin
            moved = 1'b1;
            results_seen <= results_seen + 1;
            if (expected_units.size() == 0) begin
               $display("unexpected result word at %0t", $time);
               error_count++;
            end else begin
               want = expected_units.pop_front();
               if (rsp_data.r_x !== want.r_x) report_mismatch("r_x", rsp_data.r_x, want.r_x);
               if (rsp_data.r_y !== want.r_y) report_mismatch("r_y", rsp_data.r_y, want.r_y);
               if (rsp_data.r_z !== want.r_z) report_mismatch("r_z", rsp_data.r_z, want.r_z);
               if (rsp_data.r_w !== want.r_w)
                  report_mismatch("r_w", {1'b0, rsp_data.r_w}, {1'b0, want.r_w});
               if (rsp_data.zero_norm !== want.zero_norm)
                  report_mismatch("zero_norm", {31'b0, rsp_data.zero_norm},
                                  {31'b0, want.zero_norm});
            end
         end
         quiet_cycles <= moved ? 0 : quiet_cycles + 1;
      end
   end

   // watchdog on stalled traffic
   always @(posedge clock) begin
      if (quiet_cycles >= WATCH_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // stimulus and phase control
   initial begin
      error_count = 0;
      sender_idle_pct = 17;
      receiver_idle_pct = 84;
      hold_left = 0;
      hold_armed = 1'b1;
      results_seen = 0;
      quiet_cycles = 0;
      reset = 1'b1;
      req_push = 1'b0;
      req_data = '0;
      rsp_pop = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // corner words: zero product, identities, extremes, negative scalar fold
      pending_words.push_back('0);
      pending_words.push_back(make_word(0, 0, 0, 32'h4000_0000, 0, 0, 0, 32'h4000_0000));
      pending_words.push_back(make_word(0, 0, 0, 32'hc000_0000, 0, 0, 0, 32'h4000_0000));
      pending_words.push_back(make_word(0, 0, 0, 0, 32'h7fff_ffff, 32'h7fff_ffff,
                                        32'h7fff_ffff, 32'h7fff_ffff));
      pending_words.push_back({8{32'h8000_0000}});
      pending_words.push_back({8{32'h7fff_ffff}});
      pending_words.push_back({{4{32'h8000_0000}}, {4{32'h7fff_ffff}}});
      pending_words.push_back({8{32'hffff_ffff}});
      pending_words.push_back({8{32'h0000_0001}});
      pending_words.push_back(make_word(1, 0, 0, 0, 0, 1, 0, 0));
      pending_words.push_back(make_word(32'h4000_0000, 0, 0, 0, 32'h4000_0000, 0, 0, 0));
      pending_words.push_back(make_word(0, 32'h4000_0000, 0, 0, 0, 0, 32'h4000_0000, 0));
      pending_words.push_back(make_word(32'h3fff_ffff, 0, 0, 0, 0, 0, 0, 32'h3fff_ffff));
      pending_words.push_back(make_word(0, 0, 0, 1, 0, 0, 0, 32'hffff_ffff));
      pending_words.push_back(make_word(32'h8000_0000, 0, 0, 0, 32'h8000_0000, 0, 0, 0));
      pending_words.push_back(make_word(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555,
                                        32'haaaa_aaaa, 32'haaaa_aaaa, 32'h5555_5555,
                                        32'haaaa_aaaa, 32'h5555_5555));
      pending_words.push_back(make_word(3, 3, 3, 3, 3, 3, 3, 3));
      pending_words.push_back(make_word(32'hffff_ffff, 0, 0, 0, 32'h8000_0000, 0, 0, 0));

      for (int phase = 0; phase < 3; phase++) begin
         for (int i = 0; i < 500; i++) pending_words.push_back(random_word());
         while (pending_words.size() > 0 || expected_units.size() > 0) @(posedge clock);
         // sender has paused until the block is drained
         if (phase == 0) begin
            sender_idle_pct = 84;
            receiver_idle_pct = 17;
         end else begin
            sender_idle_pct = 0;
            receiver_idle_pct = 0;
         end
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_units.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

/* quaternion_product_normalize.f */
design/qpn_pkg.sv
design/qpn_front.sv
design/qpn_queue.sv
design/qpn_back.sv
design/quaternion_product_normalize.sv
bench/tb_quaternion_product_normalize.sv
